>>> rtl/rqxf_pkg.sv
package rqxf_pkg;

    // input commands
    localparam logic [1:0] CMD_ARRIVAL  = 2'd0;
    localparam logic [1:0] CMD_DATA_SRV = 2'd1;
    localparam logic [1:0] CMD_FB_SRV   = 2'd2;

    // output ports
    localparam logic [1:0] PORT_NONE = 2'd0;
    localparam logic [1:0] PORT_APP  = 2'd1;
    localparam logic [1:0] PORT_LINK = 2'd2;

    // flow control kinds
    localparam logic [7:0] KIND_PAUSE  = 8'd2;
    localparam logic [7:0] KIND_RESUME = 8'd4;

    // start request bits
    localparam int START_DATA = 0;
    localparam int START_FB   = 1;

    // configuration register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_PAUSE    = 2'd1;
    localparam logic [1:0] CFG_RESUME   = 2'd2;

    // configuration reset values
    localparam logic [8:0] CAPACITY_RST = 9'd64;
    localparam logic [8:0] PAUSE_RST    = 9'd51;
    localparam logic [8:0] RESUME_RST   = 9'd20;

    // controller commands to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl;

endpackage

>>> rtl/rqxf_ctrl.sv
module rqxf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_done,
    output rqxf_pkg::t_ctl o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // sequence: take request, then update the queue state in S_EXEC
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy     = (r_state == S_EXEC);
    assign o_done     = r_done;
    assign o_ctl.load = (r_state == S_IDLE) && i_start;
    assign o_ctl.exec = (r_state == S_EXEC);

endmodule

>>> rtl/rqxf_datapath.sv
module rqxf_datapath #(
    parameter int DATA_DEPTH = 256,
    parameter int FB_DEPTH   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rqxf_pkg::t_ctl i_ctl,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [8:0]     i_cfg_data,
    input  logic [1:0]     i_command,
    input  logic [7:0]     i_pkt_kind,
    input  logic [15:0]    i_pkt_id,
    output logic [1:0]     o_out_port,
    output logic [7:0]     o_out_kind,
    output logic [15:0]    o_out_id,
    output logic           o_out_generated,
    output logic           o_dropped,
    output logic [31:0]    o_drop_total,
    output logic [8:0]     o_data_occupancy,
    output logic [1:0]     o_start_request
);

    localparam int DAW   = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int DCW   = $clog2(DATA_DEPTH + 1);
    localparam int FAW   = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
    localparam int FCW   = $clog2(FB_DEPTH + 1);
    localparam int LW    = (DCW > 9) ? DCW : 9;
    localparam logic [DAW-1:0] DATA_LAST = DAW'(DATA_DEPTH - 1);
    localparam logic [FAW-1:0] FB_LAST   = FAW'(FB_DEPTH - 1);

    // configuration
    logic [8:0] r_capacity, r_pause_level, r_resume_level;

    // latched request
    logic [1:0]  r_cmd;
    logic [7:0]  r_kind;
    logic [15:0] r_id;

    // queue memories and head read data
    logic [23:0] r_data_mem [DATA_DEPTH];
    logic [23:0] r_fb_mem   [FB_DEPTH];
    logic [23:0] r_data_rd, r_fb_rd;

    // queue state
    logic [DAW-1:0] r_data_head, n_data_head, r_data_tail, n_data_tail;
    logic [DCW-1:0] r_data_cnt, n_data_cnt;
    logic [FAW-1:0] r_fb_head, n_fb_head, r_fb_tail, n_fb_tail;
    logic [FCW-1:0] r_fb_cnt, n_fb_cnt;
    logic           r_pause_sent, n_pause_sent;
    logic           r_data_busy, n_data_busy, r_fb_busy, n_fb_busy;
    logic [31:0]    r_drop_cnt, n_drop_cnt;

    // result registers
    logic [1:0]  r_port, n_port;
    logic [7:0]  r_okind, n_okind;
    logic [15:0] r_oid, n_oid;
    logic        r_gen, n_gen;
    logic        r_drop, n_drop;
    logic [1:0]  r_start, n_start;

    // decisions
    logic [LW-1:0] cnt_ext, occ_ext;
    logic          arrival, is_fb_kind, data_full, fb_full;
    logic          d_ins, fb_ins, d_pop, fb_pop, send_pause, send_resume;

    always_comb begin
        cnt_ext    = LW'(r_data_cnt);
        arrival    = (r_cmd == rqxf_pkg::CMD_ARRIVAL);
        is_fb_kind = (r_kind == rqxf_pkg::KIND_PAUSE) || (r_kind == rqxf_pkg::KIND_RESUME);
        data_full  = (cnt_ext >= LW'(r_capacity)) || (cnt_ext >= LW'(DATA_DEPTH));
        fb_full    = (r_fb_cnt >= FCW'(FB_DEPTH));
        d_ins      = arrival && !data_full && !is_fb_kind;
        fb_ins     = arrival && !data_full && is_fb_kind && !fb_full;
        d_pop      = (r_cmd == rqxf_pkg::CMD_DATA_SRV) && (r_data_cnt != '0);
        fb_pop     = (r_cmd == rqxf_pkg::CMD_FB_SRV) && (r_fb_cnt != '0);
        send_pause = d_ins && (cnt_ext > LW'(r_pause_level)) && !r_pause_sent;
        send_resume = d_ins && !send_pause && (cnt_ext < LW'(r_resume_level))
                      && r_pause_sent;
    end

    // next queue state and result
    always_comb begin
        n_data_head  = r_data_head;
        n_data_tail  = r_data_tail;
        n_data_cnt   = r_data_cnt;
        n_fb_head    = r_fb_head;
        n_fb_tail    = r_fb_tail;
        n_fb_cnt     = r_fb_cnt;
        n_pause_sent = r_pause_sent;
        n_data_busy  = r_data_busy;
        n_fb_busy    = r_fb_busy;
        n_drop_cnt   = r_drop_cnt;
        n_port       = rqxf_pkg::PORT_NONE;
        n_okind      = '0;
        n_oid        = '0;
        n_gen        = 1'b0;
        n_drop       = 1'b0;
        n_start      = '0;

        // count drops, saturating
        if (arrival && !d_ins && !fb_ins) begin
            n_drop = 1'b1;
            if (r_drop_cnt != '1) begin
                n_drop_cnt = r_drop_cnt + 32'd1;
            end
        end

        // insert into the data queue with flow signal
        if (d_ins) begin
            n_data_tail = (r_data_tail == DATA_LAST) ? '0 : r_data_tail + DAW'(1);
            n_data_cnt  = r_data_cnt + DCW'(1);
            if (!r_data_busy) begin
                n_data_busy = 1'b1;
                n_start[rqxf_pkg::START_DATA] = 1'b1;
            end
            if (send_pause) begin
                n_port       = rqxf_pkg::PORT_LINK;
                n_okind      = rqxf_pkg::KIND_PAUSE;
                n_gen        = 1'b1;
                n_pause_sent = 1'b1;
            end else if (send_resume) begin
                n_port       = rqxf_pkg::PORT_LINK;
                n_okind      = rqxf_pkg::KIND_RESUME;
                n_gen        = 1'b1;
                n_pause_sent = 1'b0;
            end
        end

        // insert into the feedback queue
        if (fb_ins) begin
            n_fb_tail = (r_fb_tail == FB_LAST) ? '0 : r_fb_tail + FAW'(1);
            n_fb_cnt  = r_fb_cnt + FCW'(1);
            if (!r_fb_busy) begin
                n_fb_busy = 1'b1;
                n_start[rqxf_pkg::START_FB] = 1'b1;
            end
        end

        // data service slot
        if (r_cmd == rqxf_pkg::CMD_DATA_SRV) begin
            n_data_busy = d_pop;
            if (d_pop) begin
                n_data_head = (r_data_head == DATA_LAST) ? '0 : r_data_head + DAW'(1);
                n_data_cnt  = r_data_cnt - DCW'(1);
                n_port      = rqxf_pkg::PORT_APP;
                n_okind     = r_data_rd[23:16];
                n_oid       = r_data_rd[15:0];
            end
        end

        // feedback service slot
        if (r_cmd == rqxf_pkg::CMD_FB_SRV) begin
            n_fb_busy = fb_pop;
            if (fb_pop) begin
                n_fb_head = (r_fb_head == FB_LAST) ? '0 : r_fb_head + FAW'(1);
                n_fb_cnt  = r_fb_cnt - FCW'(1);
                n_port    = rqxf_pkg::PORT_LINK;
                n_okind   = r_fb_rd[23:16];
                n_oid     = r_fb_rd[15:0];
            end
        end
    end

    // write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= rqxf_pkg::CAPACITY_RST;
            r_pause_level  <= rqxf_pkg::PAUSE_RST;
            r_resume_level <= rqxf_pkg::RESUME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rqxf_pkg::CFG_CAPACITY: r_capacity     <= i_cfg_data;
                rqxf_pkg::CFG_PAUSE:    r_pause_level  <= i_cfg_data;
                rqxf_pkg::CFG_RESUME:   r_resume_level <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // latch the request
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_command;
            r_kind <= i_pkt_kind;
            r_id   <= i_pkt_id;
        end
    end

    // data queue memory: write at tail, read at head
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && d_ins) begin
            r_data_mem[r_data_tail] <= {r_kind, r_id};
        end
        r_data_rd <= r_data_mem[r_data_head];
    end

    // feedback queue memory: write at tail, read at head
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && fb_ins) begin
            r_fb_mem[r_fb_tail] <= {r_kind, r_id};
        end
        r_fb_rd <= r_fb_mem[r_fb_head];
    end

    // advance queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_head  <= '0;
            r_data_tail  <= '0;
            r_data_cnt   <= '0;
            r_fb_head    <= '0;
            r_fb_tail    <= '0;
            r_fb_cnt     <= '0;
            r_pause_sent <= 1'b0;
            r_data_busy  <= 1'b0;
            r_fb_busy    <= 1'b0;
            r_drop_cnt   <= '0;
        end else if (i_ctl.exec) begin
            r_data_head  <= n_data_head;
            r_data_tail  <= n_data_tail;
            r_data_cnt   <= n_data_cnt;
            r_fb_head    <= n_fb_head;
            r_fb_tail    <= n_fb_tail;
            r_fb_cnt     <= n_fb_cnt;
            r_pause_sent <= n_pause_sent;
            r_data_busy  <= n_data_busy;
            r_fb_busy    <= n_fb_busy;
            r_drop_cnt   <= n_drop_cnt;
        end
    end

    // hold the result
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_port  <= n_port;
            r_okind <= n_okind;
            r_oid   <= n_oid;
            r_gen   <= n_gen;
            r_drop  <= n_drop;
            r_start <= n_start;
        end
    end

    assign occ_ext          = LW'(r_data_cnt);
    assign o_out_port       = r_port;
    assign o_out_kind       = r_okind;
    assign o_out_id         = r_oid;
    assign o_out_generated  = r_gen;
    assign o_dropped        = r_drop;
    assign o_drop_total     = r_drop_cnt;
    assign o_data_occupancy = occ_ext[8:0];
    assign o_start_request  = r_start;

endmodule

>>> rtl/receive_queue_xon_xoff_feedback.sv
// A request taken at an accept edge is latched together with the registered read of the
// queue heads; the queue state and the result registers update at the end of S_EXEC, and
// o_done then marks the result; the receiver cannot stall and takes it while o_done is high.
// The block takes no new request while busy is high, that is while it updates the queue
// state in S_EXEC. Reset (synchronous, active low) empties both queues, clears flags and
// the drop count and restores the default levels; queue memories are not cleared.
module receive_queue_xon_xoff_feedback #(
    parameter int DATA_DEPTH = 256,
    parameter int FB_DEPTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_pkt_kind,
    input  logic [15:0] i_pkt_id,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_out_port,
    output logic [7:0]  o_out_kind,
    output logic [15:0] o_out_id,
    output logic        o_out_generated,
    output logic        o_dropped,
    output logic [31:0] o_drop_total,
    output logic [8:0]  o_data_occupancy,
    output logic [1:0]  o_start_request
);

    rqxf_pkg::t_ctl ctl;

    rqxf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctl   (ctl)
    );

    rqxf_datapath #(
        .DATA_DEPTH (DATA_DEPTH),
        .FB_DEPTH   (FB_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_pkt_kind       (i_pkt_kind),
        .i_pkt_id         (i_pkt_id),
        .o_out_port       (o_out_port),
        .o_out_kind       (o_out_kind),
        .o_out_id         (o_out_id),
        .o_out_generated  (o_out_generated),
        .o_dropped        (o_dropped),
        .o_drop_total     (o_drop_total),
        .o_data_occupancy (o_data_occupancy),
        .o_start_request  (o_start_request)
    );

endmodule

>>> tb/receive_queue_xon_xoff_feedback_tb.sv
`timescale 1ns / 1ps

module receive_queue_xon_xoff_feedback_tb;

    localparam int DATA_SLOTS  = 256;
    localparam int FB_SLOTS    = 16;
    localparam int STALL_LIMIT = 500;
    localparam int RANDOM_REQS = 1000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STEP_REQUEST,
        STEP_CONFIG,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind  what;
        logic [1:0]  command;
        logic [7:0]  pkt_kind;
        logic [15:0] pkt_id;
        logic [1:0]  cfg_index;
        logic [8:0]  cfg_data;
        int          gap;
    } t_rx_step;

    typedef struct packed {
        logic [7:0]  kind;
        logic [15:0] id;
    } t_desc;

    typedef struct packed {
        logic [1:0]  port;
        logic [7:0]  kind;
        logic [15:0] id;
        logic        generated;
        logic        dropped;
        logic [31:0] drops;
        logic [8:0]  occupancy;
        logic [1:0]  starts;
    } t_rx_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [7:0]  i_pkt_kind;
    logic [15:0] i_pkt_id;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;
    logic        o_done;
    logic [1:0]  o_out_port;
    logic [7:0]  o_out_kind;
    logic [15:0] o_out_id;
    logic        o_out_generated;
    logic        o_dropped;
    logic [31:0] o_drop_total;
    logic [8:0]  o_data_occupancy;
    logic [1:0]  o_start_request;

    receive_queue_xon_xoff_feedback #(
        .DATA_DEPTH(DATA_SLOTS),
        .FB_DEPTH  (FB_SLOTS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_pkt_kind      (i_pkt_kind),
        .i_pkt_id        (i_pkt_id),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_out_port      (o_out_port),
        .o_out_kind      (o_out_kind),
        .o_out_id        (o_out_id),
        .o_out_generated (o_out_generated),
        .o_dropped       (o_dropped),
        .o_drop_total    (o_drop_total),
        .o_data_occupancy(o_data_occupancy),
        .o_start_request (o_start_request)
    );

    // queue model state
    t_desc       data_mem [DATA_SLOTS];
    t_desc       fb_mem   [FB_SLOTS];
    logic [7:0]  data_rd, data_wr;
    logic [3:0]  fb_rd, fb_wr;
    int          data_fill, fb_fill;
    logic        pause_out;
    logic [31:0] drop_count;
    logic        data_srv_busy, fb_srv_busy;
    logic [8:0]  cap_reg, pause_reg, resume_reg;

    t_rx_step    pending_steps [$];
    t_rx_outcome outcomes_due [$];
    t_rx_step    cur_req;
    int          in_flight;
    int          gap_waited;
    int          stall_cycles;
    int          errors;
    int          reqs_queued;
    bit          no_idle;
    logic        hold_start;
    logic        cfg_write;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // advance the queue model by one request and return what the block must report
    function automatic t_rx_outcome model_rx_step(t_rx_step r);
        t_rx_outcome o;
        int          limit;
        t_desc       d;
        o = '0;
        d = '{kind: r.pkt_kind, id: r.pkt_id};
        case (r.command)
            rqxf_pkg::CMD_ARRIVAL: begin
                limit = (cap_reg < DATA_SLOTS) ? int'(cap_reg) : DATA_SLOTS;
                if (data_fill >= limit) begin
                    o.dropped = 1'b1;
                end else if (r.pkt_kind == rqxf_pkg::KIND_PAUSE
                             || r.pkt_kind == rqxf_pkg::KIND_RESUME) begin
                    if (fb_fill >= FB_SLOTS) begin
                        o.dropped = 1'b1;
                    end else begin
                        fb_mem[fb_wr] = d;
                        fb_wr++;
                        fb_fill++;
                        if (!fb_srv_busy) begin
                            fb_srv_busy = 1'b1;
                            o.starts[rqxf_pkg::START_FB] = 1'b1;
                        end
                    end
                end else begin
                    // hysteresis: one pause going up, one resume coming down
                    if (data_fill > pause_reg && !pause_out) begin
                        o.port = rqxf_pkg::PORT_LINK;
                        o.kind = rqxf_pkg::KIND_PAUSE;
                        o.generated = 1'b1;
                        pause_out = 1'b1;
                    end else if (data_fill < resume_reg && pause_out) begin
                        o.port = rqxf_pkg::PORT_LINK;
                        o.kind = rqxf_pkg::KIND_RESUME;
                        o.generated = 1'b1;
                        pause_out = 1'b0;
                    end
                    data_mem[data_wr] = d;
                    data_wr++;
                    data_fill++;
                    if (!data_srv_busy) begin
                        data_srv_busy = 1'b1;
                        o.starts[rqxf_pkg::START_DATA] = 1'b1;
                    end
                end
                if (o.dropped && drop_count != 32'hFFFF_FFFF)
                    drop_count++;
            end
            rqxf_pkg::CMD_DATA_SRV: begin
                if (data_fill > 0) begin
                    o.port = rqxf_pkg::PORT_APP;
                    o.kind = data_mem[data_rd].kind;
                    o.id = data_mem[data_rd].id;
                    data_rd++;
                    data_fill--;
                    data_srv_busy = 1'b1;
                end else begin
                    data_srv_busy = 1'b0;
                end
            end
            rqxf_pkg::CMD_FB_SRV: begin
                if (fb_fill > 0) begin
                    o.port = rqxf_pkg::PORT_LINK;
                    o.kind = fb_mem[fb_rd].kind;
                    o.id = fb_mem[fb_rd].id;
                    fb_rd++;
                    fb_fill--;
                    fb_srv_busy = 1'b1;
                end else begin
                    fb_srv_busy = 1'b0;
                end
            end
            default: ;
        endcase
        o.drops = drop_count;
        o.occupancy = data_fill[8:0];
        return o;
    endfunction

    function automatic void write_level(logic [1:0] idx, logic [8:0] value);
        case (idx)
            rqxf_pkg::CFG_CAPACITY: cap_reg = value;
            rqxf_pkg::CFG_PAUSE:    pause_reg = value;
            rqxf_pkg::CFG_RESUME:   resume_reg = value;
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // stimulus list builders
    task automatic add_request(logic [1:0] cmd, logic [7:0] kind, logic [15:0] id);
        t_rx_step s;
        s = '{what: STEP_REQUEST, command: cmd, pkt_kind: kind, pkt_id: id,
              cfg_index: rqxf_pkg::CFG_CAPACITY, cfg_data: '0, gap: 0};
        s.gap = no_idle ? 0 : int'($urandom_range(0, 9));
        pending_steps.push_back(s);
        reqs_queued++;
    endtask

    task automatic add_config(logic [1:0] idx, logic [8:0] value);
        t_rx_step s;
        s = '{what: STEP_CONFIG, command: rqxf_pkg::CMD_ARRIVAL, pkt_kind: '0, pkt_id: '0,
              cfg_index: idx, cfg_data: value, gap: 0};
        pending_steps.push_back(s);
    endtask

    task automatic add_drain();
        t_rx_step s;
        s = '{what: STEP_DRAIN, command: rqxf_pkg::CMD_ARRIVAL, pkt_kind: '0, pkt_id: '0,
              cfg_index: rqxf_pkg::CFG_CAPACITY, cfg_data: '0, gap: 0};
        pending_steps.push_back(s);
    endtask

    // mixed arrivals, service slots, unused commands and drain points, arrival_pct percent arrivals
    task automatic add_random_phase(int n_items, int arrival_pct);
        int r;
        logic [7:0] kind;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 3)
                add_drain();
            r = $urandom_range(0, 99);
            if (r < arrival_pct) begin
                if ($urandom_range(0, 4) == 0)
                    kind = $urandom_range(0, 1) ? rqxf_pkg::KIND_PAUSE : rqxf_pkg::KIND_RESUME;
                else
                    kind = 8'($urandom_range(0, 255));
                add_request(rqxf_pkg::CMD_ARRIVAL, kind, 16'($urandom));
            end else if (r < 99) begin
                add_request($urandom_range(0, 1) ? rqxf_pkg::CMD_DATA_SRV : rqxf_pkg::CMD_FB_SRV,
                            8'($urandom), 16'($urandom));
            end else begin
                add_request(CMD_UNUSED, 8'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        int cap, pl, rl, mode;
        // known values on every input before the first edge
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = rqxf_pkg::CMD_ARRIVAL;
        i_pkt_kind = '0;
        i_pkt_id = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = rqxf_pkg::CFG_CAPACITY;
        i_cfg_data = '0;
        errors = 0;
        reqs_queued = 0;
        in_flight = 0;
        gap_waited = 0;
        stall_cycles = 0;

        // model reset
        data_rd = '0; data_wr = '0; data_fill = 0;
        fb_rd = '0; fb_wr = '0; fb_fill = 0;
        pause_out = 1'b0;
        drop_count = '0;
        data_srv_busy = 1'b0;
        fb_srv_busy = 1'b0;
        cap_reg = rqxf_pkg::CAPACITY_RST;
        pause_reg = rqxf_pkg::PAUSE_RST;
        resume_reg = rqxf_pkg::RESUME_RST;

        // directed: empty service slots and the unused command
        no_idle = 1'b0;
        add_request(rqxf_pkg::CMD_DATA_SRV, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_FB_SRV, 8'hFF, 16'hFFFF);
        add_request(CMD_UNUSED, 8'hFF, 16'hFFFF);
        // directed: tiny queue, pause on the way up, drops when full
        add_config(rqxf_pkg::CFG_CAPACITY, 9'd3);
        add_config(rqxf_pkg::CFG_PAUSE, 9'd1);
        add_config(rqxf_pkg::CFG_RESUME, 9'd1);
        add_request(rqxf_pkg::CMD_ARRIVAL, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_ARRIVAL, 8'hFF, 16'hFFFF);
        add_request(rqxf_pkg::CMD_ARRIVAL, rqxf_pkg::KIND_PAUSE, 16'h1234);
        add_request(rqxf_pkg::CMD_ARRIVAL, rqxf_pkg::KIND_RESUME, 16'hABCD);
        add_request(rqxf_pkg::CMD_ARRIVAL, 8'h07, 16'h0005);
        add_request(rqxf_pkg::CMD_ARRIVAL, rqxf_pkg::KIND_PAUSE, 16'h0009);
        add_request(rqxf_pkg::CMD_ARRIVAL, 8'h09, 16'h5A5A);
        // drain the data queue, then an insert into the empty queue resumes
        add_request(rqxf_pkg::CMD_DATA_SRV, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_DATA_SRV, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_DATA_SRV, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_DATA_SRV, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_ARRIVAL, 8'h01, 16'h0007);
        add_request(rqxf_pkg::CMD_FB_SRV, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_FB_SRV, 8'h00, 16'h0000);
        add_request(rqxf_pkg::CMD_FB_SRV, 8'h00, 16'h0000);
        add_drain();
        // zero capacity drops everything, feedback kinds too
        add_config(rqxf_pkg::CFG_CAPACITY, 9'd0);
        add_request(rqxf_pkg::CMD_ARRIVAL, 8'h03, 16'h0001);
        add_request(rqxf_pkg::CMD_ARRIVAL, rqxf_pkg::KIND_RESUME, 16'h0002);

        // long fill past the physical depth with fixed levels
        add_config(rqxf_pkg::CFG_CAPACITY,
                   $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511)));
        add_config(rqxf_pkg::CFG_PAUSE, 9'd200);
        add_config(rqxf_pkg::CFG_RESUME, 9'd60);
        add_random_phase(400, 95);
        add_random_phase(60, 5);

        // random phases with fresh levels each time
        while (reqs_queued < RANDOM_REQS) begin
            mode = $urandom_range(0, 4);
            case (mode)
                0: begin
                    cap = $urandom_range(1, 8);
                    pl = $urandom_range(0, cap);
                    rl = $urandom_range(0, pl + 1);
                end
                1: begin
                    cap = $urandom_range(1, 64);
                    pl = $urandom_range(0, cap);
                    rl = $urandom_range(0, pl);
                end
                2: begin
                    cap = $urandom_range(0, 511);
                    pl = $urandom_range(0, 511);
                    rl = $urandom_range(0, 511);
                end
                3: begin
                    cap = $urandom_range(1, 16);
                    pl = 0;
                    rl = 256;
                end
                default: begin
                    cap = $urandom_range(1, 32);
                    pl = $urandom_range(0, 1) ? 256 : 511;
                    rl = 0;
                end
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            add_config(rqxf_pkg::CFG_CAPACITY, 9'(cap));
            add_config(rqxf_pkg::CFG_PAUSE, 9'(pl));
            add_config(rqxf_pkg::CFG_RESUME, 9'(rl));
            add_random_phase($urandom_range(20, 60), $urandom_range(35, 75));
        end

        // release reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests and results, then a short settle
        do @(negedge i_clk);
        while (pending_steps.size() != 0 || in_flight != 0 || start);
        repeat (8) @(negedge i_clk);
        if (outcomes_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, outcomes_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // issue requests, level writes and drain points from the step list
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
            in_flight = 0;
            gap_waited = 0;
        end else begin
            hold_start = start && busy;
            cfg_write = 1'b0;
            if (start && !busy) begin
                outcomes_due.push_back(model_rx_step(cur_req));
                in_flight++;
            end
            if (o_done)
                in_flight--;
            if (!hold_start && pending_steps.size() != 0) begin
                case (pending_steps[0].what)
                    STEP_REQUEST: begin
                        if (gap_waited < pending_steps[0].gap) begin
                            gap_waited++;
                        end else begin
                            cur_req = pending_steps.pop_front();
                            gap_waited = 0;
                            hold_start = 1'b1;
                            i_command <= cur_req.command;
                            i_pkt_kind <= cur_req.pkt_kind;
                            i_pkt_id <= cur_req.pkt_id;
                        end
                    end
                    STEP_CONFIG: begin
                        if (in_flight == 0) begin
                            cfg_write = 1'b1;
                            i_cfg_index <= pending_steps[0].cfg_index;
                            i_cfg_data <= pending_steps[0].cfg_data;
                            write_level(pending_steps[0].cfg_index, pending_steps[0].cfg_data);
                            void'(pending_steps.pop_front());
                        end
                    end
                    default: begin
                        if (in_flight == 0)
                            void'(pending_steps.pop_front());
                    end
                endcase
            end
            start <= hold_start;
            i_cfg_we <= cfg_write;
        end
    end

    // compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_rx_outcome want;
        if (i_rst_n && o_done) begin
            if (outcomes_due.size() == 0) begin
                $display("%0t: result with no request outstanding, port %0h kind %0h id %0h",
                         $time, o_out_port, o_out_kind, o_out_id);
                errors++;
            end else begin
                want = outcomes_due.pop_front();
                check_field("out_port", want.port, o_out_port);
                check_field("out_kind", want.kind, o_out_kind);
                check_field("out_id", want.id, o_out_id);
                check_field("out_generated", want.generated, o_out_generated);
                check_field("dropped", want.dropped, o_dropped);
                check_field("drop_total", want.drops, o_drop_total);
                check_field("data_occupancy", want.occupancy, o_data_occupancy);
                check_field("start_request", want.starts, o_start_request);
            end
        end
    end

    // end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

>>> files.f
rtl/rqxf_pkg.sv
rtl/rqxf_ctrl.sv
rtl/rqxf_datapath.sv
rtl/receive_queue_xon_xoff_feedback.sv
tb/receive_queue_xon_xoff_feedback_tb.sv
